FILE: rtl/core/fuzzy_logic_alu_top_macros.svh
// Assertion macros for the fuzzy logic ALU checker.
// Depends on nothing; included by the checker module only.
`ifndef FUZZY_LOGIC_ALU_TOP_MACROS_SVH
`define FUZZY_LOGIC_ALU_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fuzzy_logic_alu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fuzzy_logic_alu assertion failed");

`endif

FILE: rtl/core/fla_pkg.sv
// Shared types and constants for the fuzzy logic ALU.
// Depends on nothing; used by the datapath and the top level.
`timescale 1ns / 1ps

package fla_pkg;

  localparam int unsigned OpcodeWidth = 3;

  // Operation codes carried by each input transaction.
  typedef enum logic [OpcodeWidth-1:0] {
    OP_ADD        = 3'd0,
    OP_SUB        = 3'd1,
    OP_MUL        = 3'd2,
    OP_LESS       = 3'd3,
    OP_MIN        = 3'd4,
    OP_IMPLY      = 3'd5,
    OP_REDUCE_AND = 3'd6,
    OP_REDUCE_OR  = 3'd7
  } opcode_e;

  // Control outcome of one operation, from the datapath to the top level.
  typedef struct packed {
    logic emit;       // a result transaction is produced
    logic acc_write;  // the reduction accumulator takes a new value
  } alu_ctrl_t;

endpackage

FILE: rtl/core/fla_datapath.sv
// Combinational datapath of the fuzzy logic ALU: one shared multiplier,
// adders and compares. Depends on fla_pkg.
`timescale 1ns / 1ps

module fla_datapath #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  fla_pkg::opcode_e        opcode_i,
  input  logic [DATA_WIDTH-1:0]   operand_a_i,
  input  logic [DATA_WIDTH-1:0]   operand_b_i,
  input  logic                    last_element_i,
  input  logic [DATA_WIDTH-1:0]   acc_i,
  output logic [DATA_WIDTH-1:0]   result_o,
  output logic [DATA_WIDTH-1:0]   acc_next_o,
  output fla_pkg::alu_ctrl_t      ctrl_o
);

  localparam logic [DATA_WIDTH-1:0] One = DATA_WIDTH'(1);

  logic [DATA_WIDTH-1:0]   one_minus_a;
  logic [DATA_WIDTH-1:0]   mul_x;
  logic [DATA_WIDTH-1:0]   mul_y;
  logic [2*DATA_WIDTH-1:0] product;
  logic [DATA_WIDTH-1:0]   product_lo;
  logic                    a_less_b;
  logic signed [DATA_WIDTH:0] imply_t;
  logic signed [DATA_WIDTH:0] imply_b;
  logic [DATA_WIDTH:0]     imply_win;
  logic                    is_reduce;

  assign one_minus_a = One - operand_a_i;
  assign is_reduce   = (opcode_i == fla_pkg::OP_REDUCE_AND) ||
                       (opcode_i == fla_pkg::OP_REDUCE_OR);

  // One multiplier serves both the binary product and the reduction step.
  always_comb begin
    mul_x = is_reduce ? acc_i : operand_a_i;
    case (opcode_i)
      fla_pkg::OP_REDUCE_AND: mul_y = operand_a_i;
      fla_pkg::OP_REDUCE_OR:  mul_y = one_minus_a;
      default:                mul_y = operand_b_i;
    endcase
  end

  assign product    = {{DATA_WIDTH{1'b0}}, mul_x} * {{DATA_WIDTH{1'b0}}, mul_y};
  assign product_lo = product[DATA_WIDTH-1:0];

  assign a_less_b = $signed(operand_a_i) < $signed(operand_b_i);

  // Implication compares 1 - a one bit wider than the data, then wraps.
  assign imply_t   = $signed({operand_a_i[DATA_WIDTH-1] ^ 1'b0, operand_a_i});
  assign imply_b   = $signed({operand_b_i[DATA_WIDTH-1], operand_b_i});
  assign imply_win = ((DATA_WIDTH+1)'(1) - imply_t > imply_b) ?
                     (DATA_WIDTH+1)'((DATA_WIDTH+1)'(1) - imply_t) : imply_b;

  // Result selection and accumulator update.
  always_comb begin
    result_o         = product_lo;
    acc_next_o       = acc_i;
    ctrl_o.emit      = 1'b1;
    ctrl_o.acc_write = 1'b0;
    case (opcode_i)
      fla_pkg::OP_ADD:   result_o = operand_a_i + operand_b_i;
      fla_pkg::OP_SUB:   result_o = operand_a_i - operand_b_i;
      fla_pkg::OP_MUL:   result_o = product_lo;
      fla_pkg::OP_LESS:  result_o = a_less_b ? One : '0;
      fla_pkg::OP_MIN:   result_o = a_less_b ? operand_a_i : operand_b_i;
      fla_pkg::OP_IMPLY: result_o = imply_win[DATA_WIDTH-1:0];
      fla_pkg::OP_REDUCE_AND: begin
        result_o         = product_lo;
        ctrl_o.emit      = last_element_i;
        ctrl_o.acc_write = 1'b1;
        acc_next_o       = last_element_i ? One : product_lo;
      end
      fla_pkg::OP_REDUCE_OR: begin
        result_o         = One - product_lo;
        ctrl_o.emit      = last_element_i;
        ctrl_o.acc_write = 1'b1;
        acc_next_o       = last_element_i ? One : product_lo;
      end
      default: begin
        result_o = product_lo;
      end
    endcase
  end

endmodule

FILE: rtl/core/fuzzy_logic_alu_top.sv
// Top level of the fuzzy logic ALU: input register, datapath, result
// register and reduction accumulator. Depends on fla_pkg and fla_datapath.
//
//   channel | signals                                               | direction
//   --------+-------------------------------------------------------+----------
//   input   | in_valid_i, in_stall_o, opcode_i, operand_a_i,        | in
//           | operand_b_i, last_element_i                           |
//   output  | out_valid_o, out_stall_i, result_value_o              | out
//
// One transaction per cycle while the input is not stalled; a result is
// presented after its input passes through the input register, then the
// result register.
// The accumulator multiply is combinational, in the datapath between those two registers.
// Reset clears both valid flags and sets the accumulator to one.
// The input stalls only while a stalled result is held and the registered
// input would also produce a result.
`timescale 1ns / 1ps

module fuzzy_logic_alu_top #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            opcode_i,
  input  logic [DATA_WIDTH-1:0] operand_a_i,
  input  logic [DATA_WIDTH-1:0] operand_b_i,
  input  logic                  last_element_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0] result_value_o
);

  localparam logic [DATA_WIDTH-1:0] One = DATA_WIDTH'(1);

  logic                  s1_valid_q, s1_valid_d;
  fla_pkg::opcode_e      s1_opcode_q;
  logic [DATA_WIDTH-1:0] s1_a_q;
  logic [DATA_WIDTH-1:0] s1_b_q;
  logic                  s1_last_q;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_data_q;

  logic [DATA_WIDTH-1:0] dp_result;
  logic [DATA_WIDTH-1:0] dp_acc_next;
  fla_pkg::alu_ctrl_t    dp_ctrl;
  logic                  s1_fire;
  logic                  in_accept;

  fla_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .opcode_i      (s1_opcode_q),
    .operand_a_i   (s1_a_q),
    .operand_b_i   (s1_b_q),
    .last_element_i(s1_last_q),
    .acc_i         (acc_q),
    .result_o      (dp_result),
    .acc_next_o    (dp_acc_next),
    .ctrl_o        (dp_ctrl)
  );

  // The registered item moves on unless its result would hit a held output.
  assign s1_fire    = s1_valid_q && !(dp_ctrl.emit && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Next-state logic for the valid flags and the accumulator.
  always_comb begin
    s1_valid_d  = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    acc_d       = (s1_fire && dp_ctrl.acc_write) ? dp_acc_next : acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_fire && dp_ctrl.emit) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state and accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= One;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_opcode_q <= fla_pkg::opcode_e'(opcode_i);
      s1_a_q      <= operand_a_i;
      s1_b_q      <= operand_b_i;
      s1_last_q   <= last_element_i;
    end
    if (s1_fire && dp_ctrl.emit) begin
      out_data_q <= dp_result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_data_q;

endmodule

FILE: rtl/core/fla_checker.sv
// Port-level checker for the fuzzy logic ALU, bound to the top level.
// Depends on fuzzy_logic_alu_top_macros.svh and fuzzy_logic_alu_top.
`timescale 1ns / 1ps
`include "fuzzy_logic_alu_top_macros.svh"

module fla_checker #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [DATA_WIDTH-1:0] result_value_o
);

  // A stalled result transaction stays valid and keeps its value.
  `FLA_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `FLA_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(result_value_o))

  // The input only stalls behind a held result.
  `FLA_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A fresh result follows an input transaction accepted ahead of it through the input and result registers.
  `FLA_ASSERT_IMPL(a_result_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2))

endmodule

bind fuzzy_logic_alu_top fla_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_fla_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_value_o(result_value_o)
);

FILE: bench/tb.sv
// Self-checking testbench for fuzzy_logic_alu_top: directed table, then random traffic.
// Depends on fla_pkg and the fuzzy_logic_alu_top RTL; results are checked against an
// in-bench predictor of the ALU and its shared reduction accumulator.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DW           = 16;
  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NUM_DIRECTED = 25;

  // One row of the directed table; value is used only when known is set.
  typedef struct packed {
    fla_pkg::opcode_e op;
    logic [DW-1:0]    a;
    logic [DW-1:0]    b;
    logic             last;
    logic             known;
    logic [DW-1:0]    value;
  } alu_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [2:0]    opcode_i;
  logic [DW-1:0] operand_a_i;
  logic [DW-1:0] operand_b_i;
  logic          last_element_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [DW-1:0] result_value_o;

  // Predictor state and scoreboard.
  logic [DW-1:0] reduce_acc;
  logic [DW-1:0] pending_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_gap_max = 0;
  int unsigned   recv_gap_max = 0;
  int unsigned   stall_hold_request = 0;

  // Directed rows: extremes, every opcode, single-element and mixed reductions.
  alu_row_t directed_rows [NUM_DIRECTED] = '{
    '{fla_pkg::OP_ADD,        16'h7FFF, 16'h0001, 1'b0, 1'b1, 16'h8000},
    '{fla_pkg::OP_SUB,        16'h8000, 16'h0001, 1'b0, 1'b1, 16'h7FFF},
    '{fla_pkg::OP_MUL,        16'h8000, 16'hFFFF, 1'b0, 1'b1, 16'h8000},
    '{fla_pkg::OP_MUL,        16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 16'h0001},
    '{fla_pkg::OP_LESS,       16'h8000, 16'h7FFF, 1'b0, 1'b1, 16'h0001},
    '{fla_pkg::OP_LESS,       16'h7FFF, 16'h8000, 1'b0, 1'b1, 16'h0000},
    '{fla_pkg::OP_LESS,       16'h0005, 16'h0005, 1'b1, 1'b1, 16'h0000},
    '{fla_pkg::OP_MIN,        16'h8000, 16'h7FFF, 1'b0, 1'b1, 16'h8000},
    '{fla_pkg::OP_MIN,        16'hFFFF, 16'h0001, 1'b0, 1'b1, 16'hFFFF},
    '{fla_pkg::OP_IMPLY,      16'h8000, 16'h7FFF, 1'b0, 1'b1, 16'h8001},
    '{fla_pkg::OP_IMPLY,      16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0001},
    '{fla_pkg::OP_IMPLY,      16'h7FFF, 16'h8000, 1'b0, 1'b1, 16'h8002},
    '{fla_pkg::OP_IMPLY,      16'h0005, 16'h0003, 1'b1, 1'b1, 16'h0003},
    '{fla_pkg::OP_REDUCE_AND, 16'h1234, 16'hFFFF, 1'b1, 1'b1, 16'h1234},
    '{fla_pkg::OP_REDUCE_AND, 16'h0003, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{fla_pkg::OP_REDUCE_AND, 16'h0007, 16'h0000, 1'b1, 1'b1, 16'h0015},
    '{fla_pkg::OP_REDUCE_AND, 16'h8000, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{fla_pkg::OP_REDUCE_AND, 16'h8000, 16'h0000, 1'b1, 1'b1, 16'h0000},
    '{fla_pkg::OP_REDUCE_OR,  16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000},
    '{fla_pkg::OP_REDUCE_OR,  16'h0001, 16'h5555, 1'b1, 1'b1, 16'h0001},
    '{fla_pkg::OP_REDUCE_OR,  16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{fla_pkg::OP_REDUCE_OR,  16'h8000, 16'h0000, 1'b1, 1'b0, 16'h0000},
    '{fla_pkg::OP_REDUCE_AND, 16'h0003, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{fla_pkg::OP_REDUCE_OR,  16'h0002, 16'h0000, 1'b1, 1'b0, 16'h0000},
    '{fla_pkg::OP_REDUCE_AND, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 16'h0000}
  };

  fuzzy_logic_alu_top #(
    .DATA_WIDTH(DW)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .last_element_i(last_element_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_value_o(result_value_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Predicts one input transaction; returns 1 when it produces a result.
  function automatic bit alu_expected_result(input fla_pkg::opcode_e op,
                                             input logic [DW-1:0] a,
                                             input logic [DW-1:0] b, input logic last,
                                             output logic [DW-1:0] res);
    logic signed [DW:0] one_minus_a;
    logic [DW-1:0]      or_factor;
    res = '0;
    case (op)
      fla_pkg::OP_ADD:   res = a + b;
      fla_pkg::OP_SUB:   res = a - b;
      fla_pkg::OP_MUL:   res = a * b;
      fla_pkg::OP_LESS:  res = ($signed(a) < $signed(b)) ? DW'(1) : DW'(0);
      fla_pkg::OP_MIN:   res = ($signed(a) < $signed(b)) ? a : b;
      fla_pkg::OP_IMPLY: begin
        // 1 - a needs one extra bit; the winner is wrapped back to the data width.
        one_minus_a = $signed((DW+1)'(1)) - $signed({a[DW-1], a});
        res = (one_minus_a > $signed({b[DW-1], b})) ? one_minus_a[DW-1:0] : b;
      end
      fla_pkg::OP_REDUCE_AND: begin
        reduce_acc = reduce_acc * a;
        if (!last) return 1'b0;
        res = reduce_acc;
        reduce_acc = DW'(1);
      end
      default: begin
        or_factor = DW'(1) - a;
        reduce_acc = reduce_acc * or_factor;
        if (!last) return 1'b0;
        res = DW'(1) - reduce_acc;
        reduce_acc = DW'(1);
      end
    endcase
    return 1'b1;
  endfunction

  // Operand with a bias toward the signed extremes and zero.
  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return DW'($urandom());
    endcase
  endfunction

  // Reduction element: mostly small values so products stay nonzero for a while.
  function automatic logic [DW-1:0] pick_element();
    int small_val;
    small_val = int'($urandom_range(0, 6)) - 3;
    if ($urandom_range(0, 3) == 0) return pick_operand();
    return DW'(small_val);
  endfunction

  // Offers one input transaction, waits for its acceptance and records the expectation.
  task automatic send_item(input fla_pkg::opcode_e op, input logic [DW-1:0] a,
                           input logic [DW-1:0] b,
                           input logic last, input bit back_to_back, input bit use_typed,
                           input logic [DW-1:0] typed_value);
    int unsigned   gap;
    bit            has_result;
    logic [DW-1:0] predicted;
    gap = back_to_back ? 0 : $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    operand_a_i    <= a;
    operand_b_i    <= b;
    last_element_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    has_result = alu_expected_result(op, a, b, last, predicted);
    if (has_result) pending_results.push_back(use_typed ? typed_value : predicted);
    items_sent++;
  endtask

  // Drops valid and waits until every expected result has been delivered.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic send_binary(input bit back_to_back);
    send_item(fla_pkg::opcode_e'($urandom_range(0, 5)), pick_operand(), pick_operand(),
              1'($urandom_range(0, 1)), back_to_back, 1'b0, '0);
  endtask

  // A reduction run, sometimes mixing both reduce opcodes or interleaving binary ops.
  task automatic send_reduction_run();
    int unsigned      run_len;
    bit               mixed;
    fla_pkg::opcode_e base_op;
    fla_pkg::opcode_e op;
    run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    mixed   = ($urandom_range(0, 3) == 0);
    base_op = $urandom_range(0, 1) ? fla_pkg::OP_REDUCE_OR : fla_pkg::OP_REDUCE_AND;
    for (int unsigned i = 0; i < run_len; i++) begin
      if ($urandom_range(0, 9) == 0) send_binary(1'b0);
      op = mixed ? ($urandom_range(0, 1) ? fla_pkg::OP_REDUCE_OR : fla_pkg::OP_REDUCE_AND)
                 : base_op;
      send_item(op, pick_element(), DW'($urandom()), i == run_len - 1, 1'b0, 1'b0, '0);
    end
  endtask

  task automatic note_failure(input string what, input logic [DW-1:0] want,
                              input logic [DW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s, expected %h, actual %h",
               cycle_count, what, want, got);
  endtask

  // Result checker: each accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    logic [DW-1:0] want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        note_failure("result with no transaction pending", 'x, result_value_o);
      end else begin
        want = pending_results.pop_front();
        if (result_value_o !== want) note_failure("result_value", want, result_value_o);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL fuzzy_logic_alu_top");
      $finish;
    end
  end

  // Result receiver: random stall before each result, plus any requested long hold.
  initial begin : result_sink
    int unsigned wait_cycles;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      wait_cycles = $urandom_range(0, recv_gap_max) + stall_hold_request;
      stall_hold_request = 0;
      if (wait_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
    end
  end

  // Main sequence: reset, directed table, random traffic, drain and verdict.
  initial begin : stimulus
    bit hold_done;
    bit pause_done;
    hold_done      = 1'b0;
    pause_done     = 1'b0;
    reduce_acc     = DW'(1);
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    opcode_i       <= fla_pkg::OP_ADD;
    operand_a_i    <= '0;
    operand_b_i    <= '0;
    last_element_i <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; idling stays on so gaps land between these too.
    send_gap_max = 3;
    recv_gap_max = 3;
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].last, 1'b0, directed_rows[i].known, directed_rows[i].value);

    // Random traffic in phases; each phase picks whether either side idles.
    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      if ((items_sent % 150) < 8) begin
        send_gap_max = $urandom_range(0, 1) ? 13 : 0;
        recv_gap_max = $urandom_range(0, 1) ? 13 : 0;
      end
      // Long receiver hold while the sender keeps pushing results back to back.
      if (!hold_done && items_sent >= 600) begin
        hold_done = 1'b1;
        stall_hold_request = LONG_HOLD;
        repeat (30) send_binary(1'b1);
      end
      // Sender pause until the block has delivered everything.
      if (!pause_done && items_sent >= 1200) begin
        pause_done = 1'b1;
        wait_results_drained();
      end
      if ($urandom_range(0, 9) < 5) send_binary(1'b0);
      else send_reduction_run();
    end

    // Drain every expected result, then give the block time for stray outputs.
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS fuzzy_logic_alu_top");
    end else begin
      $display("FAIL fuzzy_logic_alu_top");
    end
    $finish;
  end

endmodule
